>>> src/stt_pkg.sv
`default_nettype none

package stt_pkg;

    // width of the internal line and column counters
    localparam int POS_BITS = 16;
    // an item causes at most three results (e.g. "::" gives two bytes and an end)
    localparam int RES_MAX  = 3;
    localparam int CNT_BITS = $clog2(RES_MAX + 1);

    typedef logic [POS_BITS-1:0] pos_t;
    typedef logic [CNT_BITS-1:0] cnt_t;

    typedef enum logic [1:0] {
        EV_TEXT  = 2'd0,
        EV_END   = 2'd1,
        EV_ERROR = 2'd2
    } event_t;

    typedef enum logic [2:0] {
        KIND_WORD   = 3'd0,
        KIND_INT    = 3'd1,
        KIND_FLOAT  = 3'd2,
        KIND_STRING = 3'd3,
        KIND_SYMBOL = 3'd4,
        KIND_EOS    = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ERR_BLOCK  = 2'd0,
        ERR_ESCAPE = 2'd1,
        ERR_STRING = 2'd2,
        ERR_CHAR   = 2'd3
    } err_t;

    typedef struct packed {
        event_t      ev;
        kind_t       kind;
        logic [7:0]  text_byte;
        logic [15:0] line;
        logic [15:0] column;
        err_t        err;
    } res_t;

    typedef struct packed {
        res_t [RES_MAX-1:0] res;
        cnt_t               cnt;
    } res_grp_t;

endpackage

`default_nettype wire

>>> src/stt_scan.sv
`default_nettype none

module stt_scan (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              fire,
    input  wire logic [7:0]        in_char,
    input  wire logic              in_end,
    output stt_pkg::res_grp_t      grp
);
    import stt_pkg::*;

    typedef enum logic [2:0] {
        M_IDLE,
        M_LINE,
        M_BLOCK,
        M_STRING,
        M_ESCAPE,
        M_NUMBER,
        M_WORD
    } mode_t;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] held_byte;
        logic       held_valid;
        logic       quote_single;
        logic       seen_dot;
        logic       word_path;
        logic       skip_next;
        logic       err_latched;
        pos_t       cur_line;
        pos_t       cur_col;
        pos_t       start_line;
        pos_t       start_col;
    } scan_st_t;

    typedef struct packed {
        scan_st_t st;
        res_grp_t grp;
    } step_out_t;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_T     = 8'h74;

    localparam scan_st_t SCAN_RST = '{
        mode:         M_IDLE,
        held_byte:    8'd0,
        held_valid:   1'b0,
        quote_single: 1'b0,
        seen_dot:     1'b0,
        word_path:    1'b0,
        skip_next:    1'b0,
        err_latched:  1'b0,
        cur_line:     pos_t'(1),
        cur_col:      pos_t'(1),
        start_line:   pos_t'(1),
        start_col:    pos_t'(1)
    };

    scan_st_t  st_reg;
    scan_st_t  st_next;
    step_out_t o;

    function automatic logic [15:0] sat16(pos_t v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_pathy(logic [7:0] c);
        return c == CH_DOT || c == CH_SLASH || c == CH_BSL;
    endfunction

    function automatic logic word_cont(logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == CH_UNDER || is_pathy(c);
    endfunction

    function automatic logic is_symbol(logic [7:0] c);
        return c == "{" || c == "}" || c == "[" || c == "]" || c == "(" || c == ")" ||
               c == ";" || c == "," || c == ":" || c == "=" || c == "!" || c == "-" ||
               c == "+";
    endfunction

    // advance the cursor past byte c, saturating
    function automatic scan_st_t step_pos(scan_st_t s, logic [7:0] c);
        scan_st_t r;
        r = s;
        if (c == CH_LF) begin
            if (s.cur_line != '1) begin
                r.cur_line = s.cur_line + pos_t'(1);
            end
            r.cur_col = pos_t'(1);
        end else if (s.cur_col != '1) begin
            r.cur_col = s.cur_col + pos_t'(1);
        end
        return r;
    endfunction

    function automatic step_out_t push(step_out_t so, event_t ev, kind_t kind,
                                      logic [7:0] b, pos_t ln, pos_t col, err_t err);
        step_out_t r;
        res_t      e;
        r = so;
        e.ev        = ev;
        e.kind      = kind;
        e.text_byte = b;
        e.line      = sat16(ln);
        e.column    = sat16(col);
        e.err       = err;
        r.grp.res[r.grp.cnt] = e;
        r.grp.cnt = r.grp.cnt + cnt_t'(1);
        return r;
    endfunction

    function automatic step_out_t put_text(step_out_t so, logic [7:0] b);
        return push(so, EV_TEXT, KIND_WORD, b, so.st.start_line, so.st.start_col, ERR_BLOCK);
    endfunction

    function automatic step_out_t put_end(step_out_t so, kind_t kind);
        return push(so, EV_END, kind, 8'd0, so.st.start_line, so.st.start_col, ERR_BLOCK);
    endfunction

    function automatic step_out_t put_error(step_out_t so, err_t code);
        step_out_t r;
        r = push(so, EV_ERROR, KIND_WORD, 8'd0, so.st.start_line, so.st.start_col, code);
        r.st.err_latched = 1'b1;
        return r;
    endfunction

    function automatic step_out_t number_body(step_out_t so, logic [7:0] c, logic hasn,
                                             logic [7:0] n);
        step_out_t r;
        r = put_text(so, c);
        if (c == CH_DOT) begin
            r.st.seen_dot = 1'b1;
        end
        r.st = step_pos(r.st, c);
        if (!(hasn && (is_digit(n) || (!r.st.seen_dot && n == CH_DOT)))) begin
            r = put_end(r, r.st.seen_dot ? KIND_FLOAT : KIND_INT);
            r.st.mode = M_IDLE;
        end
        return r;
    endfunction

    function automatic step_out_t word_body(step_out_t so, logic [7:0] c, logic hasn,
                                           logic [7:0] n);
        step_out_t r;
        r = put_text(so, c);
        if (is_pathy(c)) begin
            r.st.word_path = 1'b1;
        end
        r.st = step_pos(r.st, c);
        if (!(hasn && word_cont(n))) begin
            r = put_end(r, r.st.word_path ? KIND_STRING : KIND_WORD);
            r.st.mode = M_IDLE;
        end
        return r;
    endfunction

    // judge byte c with lookahead n (present when hasn)
    function automatic step_out_t process(scan_st_t s, logic [7:0] c, logic hasn,
                                         logic [7:0] n);
        step_out_t r;
        r.st  = s;
        r.grp = '0;
        if (s.skip_next) begin
            r.st.skip_next = 1'b0;
            r.st = step_pos(r.st, c);
        end else begin
            unique case (s.mode)
                M_LINE: begin
                    if (c == CH_LF) begin
                        r.st.mode = M_IDLE;
                    end
                    r.st = step_pos(r.st, c);
                end
                M_BLOCK: begin
                    if (c == CH_STAR && hasn && n == CH_STAR) begin
                        r.st.skip_next = 1'b1;
                        r.st.mode = M_IDLE;
                    end
                    r.st = step_pos(r.st, c);
                end
                M_ESCAPE: begin
                    r = put_text(r, (c == CH_N) ? CH_LF : ((c == CH_T) ? CH_TAB : c));
                    r.st.mode = M_STRING;
                    r.st = step_pos(r.st, c);
                end
                M_STRING: begin
                    if (c == (s.quote_single ? CH_SQ : CH_DQ)) begin
                        r = put_end(r, KIND_STRING);
                        r.st.mode = M_IDLE;
                    end else if (c == CH_BSL) begin
                        r.st.mode = M_ESCAPE;
                    end else begin
                        r = put_text(r, c);
                    end
                    r.st = step_pos(r.st, c);
                end
                M_NUMBER: r = number_body(r, c, hasn, n);
                M_WORD:   r = word_body(r, c, hasn, n);
                default: begin
                    r.st.mode = M_IDLE;
                    if (is_space(c)) begin
                        r.st = step_pos(r.st, c);
                    end else begin
                        r.st.start_line = s.cur_line;
                        r.st.start_col  = s.cur_col;
                        if (c == CH_STAR) begin
                            if (hasn && n == CH_STAR) begin
                                r.st.mode = M_BLOCK;
                                r.st.skip_next = 1'b1;
                            end else begin
                                r.st.mode = M_LINE;
                            end
                            r.st = step_pos(r.st, c);
                        end else if (c == CH_DQ || c == CH_SQ) begin
                            r.st.quote_single = (c == CH_SQ);
                            r.st.mode = M_STRING;
                            r.st = step_pos(r.st, c);
                        end else if (is_digit(c) || (c == CH_DOT && hasn && is_digit(n))) begin
                            r.st.mode = M_NUMBER;
                            r.st.seen_dot = 1'b0;
                            r = number_body(r, c, hasn, n);
                        end else if (is_alpha(c) || c == CH_UNDER || c == CH_DOT) begin
                            r.st.mode = M_WORD;
                            r.st.word_path = 1'b0;
                            r = word_body(r, c, hasn, n);
                        end else if (c == CH_COLON && hasn && n == CH_COLON) begin
                            r = put_text(r, CH_COLON);
                            r = put_text(r, CH_COLON);
                            r = put_end(r, KIND_SYMBOL);
                            r.st.skip_next = 1'b1;
                            r.st = step_pos(r.st, c);
                        end else if (is_symbol(c)) begin
                            r = put_text(r, c);
                            r = put_end(r, KIND_SYMBOL);
                            r.st = step_pos(r.st, c);
                        end else begin
                            r = put_error(r, ERR_CHAR);
                        end
                    end
                end
            endcase
        end
        return r;
    endfunction

    always_comb begin
        o.st  = st_reg;
        o.grp = '0;
        if (in_end) begin
            // flush the held byte, report anything left open, then close the source
            if (!st_reg.err_latched && st_reg.held_valid) begin
                o = process(st_reg, st_reg.held_byte, 1'b0, 8'd0);
            end
            if (!o.st.err_latched) begin
                if (o.st.mode == M_BLOCK) begin
                    o = put_error(o, ERR_BLOCK);
                end else if (o.st.mode == M_ESCAPE) begin
                    o = put_error(o, ERR_ESCAPE);
                end else if (o.st.mode == M_STRING) begin
                    o = put_error(o, ERR_STRING);
                end
            end
            if (!o.st.err_latched) begin
                o = push(o, EV_END, KIND_EOS, 8'd0, o.st.cur_line, o.st.cur_col, ERR_BLOCK);
            end
            st_next = SCAN_RST;
        end else begin
            if (!st_reg.err_latched) begin
                if (st_reg.held_valid) begin
                    o = process(st_reg, st_reg.held_byte, 1'b1, in_char);
                end
                o.st.held_byte  = in_char;
                o.st.held_valid = 1'b1;
            end
            st_next = o.st;
        end
    end

    assign grp = o.grp;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= SCAN_RST;
        end else if (fire) begin
            st_reg <= st_next;
        end
    end

endmodule

`default_nettype wire

>>> src/source_text_tokenizer.sv
// source_text_tokenizer: streaming tokenizer, one source byte or end marker per item
// path: an item is held in the input register and its results in the result register
// throughput: one item per cycle while m_ready is high and each item gives at most one
//   result; an item's k results (at most 3) hold the result register until all leave
// reset: synchronous active-low aresetn returns the scanner to the start of a source
//   (line 1, column 1, nothing held) and empties the input and result registers
`default_nettype none

module source_text_tokenizer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_char_byte,
    input  wire logic        s_is_end,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_event_res,
    output logic [2:0]       m_kind,
    output logic [7:0]       m_text_byte,
    output logic [15:0]      m_line,
    output logic [15:0]      m_column,
    output logic [1:0]       m_error_code,
    output logic             m_last_of_run
);
    import stt_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_end_reg;
    res_grp_t   grp_reg;
    cnt_t       grp_ptr_reg;
    res_grp_t   scan_grp;
    res_t       cur_res;
    logic       out_take;
    logic       grp_done;
    logic       fire;

    stt_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .in_char (in_char_reg),
        .in_end  (in_end_reg),
        .grp     (scan_grp)
    );

    assign m_valid  = (grp_ptr_reg != grp_reg.cnt);
    assign out_take = m_valid && m_ready;
    // the result group frees up when it is empty or when its last result leaves
    assign grp_done = !m_valid || (out_take && grp_ptr_reg == grp_reg.cnt - cnt_t'(1));
    assign fire     = in_valid_reg && grp_done;
    assign s_ready  = !in_valid_reg || fire;

    assign cur_res       = grp_reg.res[grp_ptr_reg];
    assign m_event_res   = cur_res.ev;
    assign m_kind        = cur_res.kind;
    assign m_text_byte   = cur_res.text_byte;
    assign m_line        = cur_res.line;
    assign m_column      = cur_res.column;
    assign m_error_code  = cur_res.err;
    assign m_last_of_run = (grp_ptr_reg == grp_reg.cnt - cnt_t'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_char_byte;
            in_end_reg  <= s_is_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            grp_reg.res <= scan_grp.res;
        end
        if (!aresetn) begin
            grp_reg.cnt <= '0;
            grp_ptr_reg <= '0;
        end else if (fire) begin
            grp_reg.cnt <= scan_grp.cnt;
            grp_ptr_reg <= '0;
        end else if (out_take) begin
            grp_ptr_reg <= grp_ptr_reg + cnt_t'(1);
        end
    end

    a_ptr_in_group: assert property (@(posedge aclk) disable iff (!aresetn)
        grp_ptr_reg <= grp_reg.cnt)
        else $error("result pointer ran past the group");

    a_error_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res == EV_ERROR |-> m_last_of_run)
        else $error("error result is not the last of its item");

    a_eos_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res == EV_END && m_kind == KIND_EOS |-> m_last_of_run)
        else $error("end-of-source token is not the last of its item");

    a_item_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !fire |=> in_valid_reg && $stable(in_char_reg)
            && $stable(in_end_reg))
        else $error("stalled item lost from the input register");

endmodule

`default_nettype wire

>>> test/tb_source_text_tokenizer.sv
module tb_source_text_tokenizer;

    import stt_pkg::*;

    localparam int unsigned POS_MAX = 32'((64'd1 << POS_BITS) - 64'd1);
    localparam int          SRC_GOAL = 470;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_STAR   = "*";
    localparam logic [7:0] CH_DQUOTE = "\"";
    localparam logic [7:0] CH_SQUOTE = "'";
    localparam logic [7:0] CH_BSLASH = "\\";
    localparam logic [7:0] CH_SLASH  = "/";
    localparam logic [7:0] CH_DOT    = ".";
    localparam logic [7:0] CH_UNDER  = "_";
    localparam logic [7:0] CH_COLON  = ":";
    localparam logic [7:0] CH_ZERO   = "0";
    localparam logic [7:0] CH_LOW_N  = "n";
    localparam logic [7:0] CH_LOW_T  = "t";

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_LINE,
        SCAN_BLOCK,
        SCAN_STRING,
        SCAN_ESCAPE,
        SCAN_NUMBER,
        SCAN_WORD
    } scan_t;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_PERIODIC,
        RDY_SPARSE
    } ready_pat_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_end;
    } src_item_t;

    typedef struct packed {
        event_t      ev;
        kind_t       kind;
        logic [7:0]  text;
        logic [15:0] line;
        logic [15:0] column;
        err_t        err;
        logic        last;
    } token_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_char_byte = 8'h00;
    logic        s_is_end = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_event_res;
    logic [2:0]  m_kind;
    logic [7:0]  m_text_byte;
    logic [15:0] m_line;
    logic [15:0] m_column;
    logic [1:0]  m_error_code;
    logic        m_last_of_run;

    string alpha_chars  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
    string symbol_chars = "{}[]();,:=!-+";
    string path_chars   = "./\\";
    string blank_chars  = " \t\n\013\014\r";

    src_item_t  source_q[$];
    token_res_t tokens_due[$];
    int         src_cnt = 0;
    int         item_total = 0;
    int         accepted_cnt = 0;
    int         mismatch_cnt = 0;

    // scanner state of the predictor
    logic [7:0]  held_q;
    bit          held_ok;
    scan_t       scan_st;
    bit          single_q;
    bit          dot_seen;
    bit          path_word;
    bit          skip_one;
    bit          halted;
    int unsigned ln_cur, col_cur, ln_tok, col_tok;
    int          step_cnt;

    source_text_tokenizer uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_byte   (s_char_byte),
        .s_is_end      (s_is_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_res   (m_event_res),
        .m_kind        (m_kind),
        .m_text_byte   (m_text_byte),
        .m_line        (m_line),
        .m_column      (m_column),
        .m_error_code  (m_error_code),
        .m_last_of_run (m_last_of_run)
    );

    always #5 aclk = ~aclk;

    function automatic bit digit_c(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit letter_c(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit blank_c(logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit path_c(logic [7:0] c);
        return c == CH_DOT || c == CH_SLASH || c == CH_BSLASH;
    endfunction

    function automatic bit word_tail_c(logic [7:0] c);
        return letter_c(c) || digit_c(c) || c == CH_UNDER || path_c(c);
    endfunction

    function automatic bit symbol_c(logic [7:0] c);
        for (int i = 0; i < symbol_chars.len(); i++)
            if (symbol_chars[i] == c) return 1'b1;
        return 1'b0;
    endfunction

    task automatic clear_scanner();
        held_q = 8'h00;
        held_ok = 1'b0;
        scan_st = SCAN_IDLE;
        single_q = 1'b0;
        dot_seen = 1'b0;
        path_word = 1'b0;
        skip_one = 1'b0;
        halted = 1'b0;
        ln_cur = 1;
        col_cur = 1;
        ln_tok = 1;
        col_tok = 1;
    endtask

    task automatic emit(event_t ev, kind_t k, logic [7:0] b, int unsigned ln,
                        int unsigned col, err_t e);
        token_res_t r;
        r.ev = ev;
        r.kind = k;
        r.text = b;
        r.line = (ln > 65535) ? 16'hFFFF : ln[15:0];
        r.column = (col > 65535) ? 16'hFFFF : col[15:0];
        r.err = e;
        r.last = 1'b0;
        tokens_due = {tokens_due, r};
        step_cnt++;
    endtask

    // kind and code read as zero outside token ends and errors
    task automatic emit_text(logic [7:0] b);
        emit(EV_TEXT, KIND_WORD, b, ln_tok, col_tok, ERR_BLOCK);
    endtask

    task automatic emit_close(kind_t k);
        emit(EV_END, k, 8'h00, ln_tok, col_tok, ERR_BLOCK);
    endtask

    task automatic emit_fault(err_t e);
        emit(EV_ERROR, KIND_WORD, 8'h00, ln_tok, col_tok, e);
        halted = 1'b1;
    endtask

    task automatic advance_pos(logic [7:0] c);
        if (c == CH_LF) begin
            if (ln_cur < POS_MAX) ln_cur++;
            col_cur = 1;
        end else if (col_cur < POS_MAX) begin
            col_cur++;
        end
    endtask

    task automatic number_char(logic [7:0] c, bit has_next, logic [7:0] n);
        emit_text(c);
        if (c == CH_DOT) dot_seen = 1'b1;
        advance_pos(c);
        if (!(has_next && (digit_c(n) || (!dot_seen && n == CH_DOT)))) begin
            emit_close(dot_seen ? KIND_FLOAT : KIND_INT);
            scan_st = SCAN_IDLE;
        end
    endtask

    task automatic word_char(logic [7:0] c, bit has_next, logic [7:0] n);
        emit_text(c);
        if (path_c(c)) path_word = 1'b1;
        advance_pos(c);
        if (!(has_next && word_tail_c(n))) begin
            emit_close(path_word ? KIND_STRING : KIND_WORD);
            scan_st = SCAN_IDLE;
        end
    endtask

    // judge byte c with lookahead n
    task automatic scan_char(logic [7:0] c, bit has_next, logic [7:0] n);
        if (skip_one) begin
            skip_one = 1'b0;
            advance_pos(c);
        end else begin
            case (scan_st)
                SCAN_LINE: begin
                    if (c == CH_LF) scan_st = SCAN_IDLE;
                    advance_pos(c);
                end
                SCAN_BLOCK: begin
                    if (c == CH_STAR && has_next && n == CH_STAR) begin
                        skip_one = 1'b1;
                        scan_st = SCAN_IDLE;
                    end
                    advance_pos(c);
                end
                SCAN_ESCAPE: begin
                    emit_text(c == CH_LOW_N ? CH_LF : (c == CH_LOW_T ? CH_TAB : c));
                    scan_st = SCAN_STRING;
                    advance_pos(c);
                end
                SCAN_STRING: begin
                    if (c == (single_q ? CH_SQUOTE : CH_DQUOTE)) begin
                        emit_close(KIND_STRING);
                        scan_st = SCAN_IDLE;
                    end else if (c == CH_BSLASH) begin
                        scan_st = SCAN_ESCAPE;
                    end else begin
                        emit_text(c);
                    end
                    advance_pos(c);
                end
                SCAN_NUMBER: number_char(c, has_next, n);
                SCAN_WORD: word_char(c, has_next, n);
                default: begin
                    if (blank_c(c)) begin
                        advance_pos(c);
                    end else begin
                        ln_tok = ln_cur;
                        col_tok = col_cur;
                        if (c == CH_STAR) begin
                            skip_one = has_next && n == CH_STAR;
                            scan_st = skip_one ? SCAN_BLOCK : SCAN_LINE;
                            advance_pos(c);
                        end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
                            single_q = (c == CH_SQUOTE);
                            scan_st = SCAN_STRING;
                            advance_pos(c);
                        end else if (digit_c(c) || (c == CH_DOT && has_next && digit_c(n))) begin
                            scan_st = SCAN_NUMBER;
                            dot_seen = 1'b0;
                            number_char(c, has_next, n);
                        end else if (letter_c(c) || c == CH_UNDER || c == CH_DOT) begin
                            scan_st = SCAN_WORD;
                            path_word = 1'b0;
                            word_char(c, has_next, n);
                        end else if (c == CH_COLON && has_next && n == CH_COLON) begin
                            emit_text(CH_COLON);
                            emit_text(CH_COLON);
                            emit_close(KIND_SYMBOL);
                            skip_one = 1'b1;
                            advance_pos(c);
                        end else if (symbol_c(c)) begin
                            emit_text(c);
                            emit_close(KIND_SYMBOL);
                            advance_pos(c);
                        end else begin
                            emit_fault(ERR_CHAR);
                        end
                    end
                end
            endcase
        end
    endtask

    task automatic tokenize_item(logic [7:0] b, logic end_mark);
        step_cnt = 0;
        if (end_mark) begin
            if (!halted && held_ok) scan_char(held_q, 1'b0, 8'h00);
            if (!halted) begin
                if (scan_st == SCAN_BLOCK) emit_fault(ERR_BLOCK);
                else if (scan_st == SCAN_ESCAPE) emit_fault(ERR_ESCAPE);
                else if (scan_st == SCAN_STRING) emit_fault(ERR_STRING);
            end
            if (!halted) emit(EV_END, KIND_EOS, 8'h00, ln_cur, col_cur, ERR_BLOCK);
            clear_scanner();
        end else if (!halted) begin
            if (held_ok) scan_char(held_q, 1'b1, b);
            held_q = b;
            held_ok = 1'b1;
        end
        if (step_cnt > 0) tokens_due[tokens_due.size() - 1].last = 1'b1;
    endtask

    // ---------------- source text generation ----------------

    function automatic logic [7:0] pick_char(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    task automatic put_byte(logic [7:0] b, bit counted);
        src_item_t it;
        it.ch = b;
        it.is_end = 1'b0;
        source_q = {source_q, it};
        if (counted) src_cnt++;
    endtask

    task automatic put_str(string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i], 1'b1);
    endtask

    task automatic put_end_marker();
        src_item_t it;
        // the byte lane is don't-care on an end marker
        it.ch = 8'($urandom);
        it.is_end = 1'b1;
        source_q = {source_q, it};
        src_cnt++;
    endtask

    task automatic put_digits(int lo, int hi);
        repeat ($urandom_range(lo, hi)) put_byte(8'(CH_ZERO + $urandom_range(0, 9)), 1'b1);
    endtask

    task automatic gen_token();
        logic [7:0] q;
        logic [7:0] b;
        bit         pathy;
        case ($urandom_range(0, 5))
            0: begin
                pathy = ($urandom_range(0, 2) == 0);
                put_byte(($urandom_range(0, 5) == 0) ? CH_UNDER : pick_char(alpha_chars), 1'b1);
                repeat ($urandom_range(0, 6)) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: put_byte(pick_char(alpha_chars), 1'b1);
                        5, 6: put_digits(1, 1);
                        7: put_byte(CH_UNDER, 1'b1);
                        default: put_byte(pathy ? pick_char(path_chars)
                                                : pick_char(alpha_chars), 1'b1);
                    endcase
                end
            end
            1: put_digits(1, 5);
            2: begin
                if ($urandom_range(0, 3) == 0) begin
                    // leading dot
                    put_byte(CH_DOT, 1'b1);
                    put_digits(1, 3);
                end else begin
                    put_digits(1, 3);
                    put_byte(CH_DOT, 1'b1);
                    put_digits(0, 3);
                end
            end
            3: begin
                q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
                put_byte(q, 1'b1);
                repeat ($urandom_range(0, 6)) begin
                    if ($urandom_range(0, 4) == 0) begin
                        put_byte(CH_BSLASH, 1'b1);
                        case ($urandom_range(0, 2))
                            0: put_byte(CH_LOW_N, 1'b1);
                            1: put_byte(CH_LOW_T, 1'b1);
                            default: put_byte(8'($urandom), 1'b1);
                        endcase
                    end else begin
                        do b = 8'($urandom); while (b == q || b == CH_BSLASH);
                        put_byte(b, 1'b1);
                    end
                end
                put_byte(q, 1'b1);
            end
            4: begin
                if ($urandom_range(0, 3) == 0) put_str("::");
                else put_byte(pick_char(symbol_chars), 1'b1);
            end
            default: begin
                // word that opens with a dot, so always a path
                put_byte(CH_DOT, 1'b1);
                repeat ($urandom_range(1, 4))
                    put_byte(($urandom_range(0, 2) == 0) ? CH_SLASH
                                                         : pick_char(alpha_chars), 1'b1);
            end
        endcase
    endtask

    task automatic gen_gap();
        logic [7:0] b;
        case ($urandom_range(0, 7))
            0, 1, 2, 3: repeat ($urandom_range(1, 3)) put_byte(pick_char(blank_chars), 1'b1);
            4: begin
                put_byte(CH_STAR, 1'b1);
                for (int i = $urandom_range(0, 8); i > 0; i--) begin
                    do b = 8'($urandom); while (b == CH_LF || b == CH_STAR);
                    put_byte(b, 1'b1);
                end
                put_byte(CH_LF, 1'b1);
            end
            5: begin
                put_str("**");
                repeat ($urandom_range(0, 8)) begin
                    do b = 8'($urandom); while (b == CH_STAR);
                    put_byte(b, 1'b1);
                end
                put_str("**");
            end
            default: ;
        endcase
    endtask

    // ---------------- stimulus ----------------

    initial begin : stimulus
        int         shape;
        logic [7:0] b;

        // a path, a float, a string with an escape, "::", then each error kind
        put_str("a/ 7.5 'x\\n' ::");
        put_end_marker();
        put_str("\"\\");
        put_end_marker();
        put_str("**");
        put_end_marker();
        put_str("\"");
        put_end_marker();
        put_byte(8'hFF, 1'b1);
        put_byte(8'h00, 1'b0);
        put_end_marker();

        while (src_cnt < SRC_GOAL) begin
            shape = $urandom_range(0, 9);
            if (shape == 9) begin
                repeat ($urandom_range(1, 6)) put_byte(8'($urandom), 1'b1);
            end else begin
                if ($urandom_range(0, 3) == 0) gen_gap();
                repeat ($urandom_range(0, 8)) begin
                    gen_token();
                    gen_gap();
                end
                if (shape == 7) begin
                    case ($urandom_range(0, 2))
                        0: begin
                            put_byte($urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE, 1'b1);
                            repeat ($urandom_range(0, 4)) put_byte(pick_char(alpha_chars), 1'b1);
                        end
                        1: begin
                            put_byte($urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE, 1'b1);
                            repeat ($urandom_range(0, 3)) put_byte(pick_char(alpha_chars), 1'b1);
                            put_byte(CH_BSLASH, 1'b1);
                        end
                        default: begin
                            put_str("**");
                            repeat ($urandom_range(0, 4)) begin
                                do b = 8'($urandom); while (b == CH_STAR);
                                put_byte(b, 1'b1);
                            end
                        end
                    endcase
                end else if (shape == 8) begin
                    do b = 8'($urandom);
                    while (blank_c(b) || digit_c(b) || letter_c(b) || symbol_c(b) ||
                           b == CH_UNDER || b == CH_DOT || b == CH_STAR ||
                           b == CH_SQUOTE || b == CH_DQUOTE);
                    put_byte(b, 1'b1);
                    // dropped by the block until the end marker
                    repeat ($urandom_range(0, 3)) put_byte(8'($urandom), 1'b0);
                end
            end
            put_end_marker();
        end
        item_total = source_q.size();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (accepted_cnt < item_total) @(posedge aclk);
        while (tokens_due.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (mismatch_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // ---------------- driver ----------------

    int        burst_left = 1;
    int        gap_left = 0;
    src_item_t next_item;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            clear_scanner();
        end else begin
            if (s_valid && s_ready) begin
                tokenize_item(s_char_byte, s_is_end);
                accepted_cnt++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0 || source_q.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    s_valid <= 1'b0;
                end else begin
                    next_item = source_q.pop_front();
                    s_valid <= 1'b1;
                    s_char_byte <= next_item.ch;
                    s_is_end <= next_item.is_end;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
            end
        end
    end

    // ---------------- receiver ----------------

    ready_pat_t rdy_pat = RDY_ALWAYS;
    int         pat_left = 0;
    int         tick = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (pat_left == 0) begin
                rdy_pat = ready_pat_t'($urandom_range(0, 3));
                pat_left = $urandom_range(16, 160);
            end else begin
                pat_left--;
            end
            tick++;
            case (rdy_pat)
                RDY_ALWAYS: m_ready <= 1'b1;
                RDY_COIN: m_ready <= ($urandom_range(0, 1) == 1);
                RDY_PERIODIC: m_ready <= (tick % 3 != 0);
                default: m_ready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    // ---------------- monitor ----------------

    token_res_t got, want;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got.ev = event_t'(m_event_res);
            got.kind = kind_t'(m_kind);
            got.text = m_text_byte;
            got.line = m_line;
            got.column = m_column;
            got.err = err_t'(m_error_code);
            got.last = m_last_of_run;
            if (tokens_due.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("%0t: result with none due: ev=%0d kind=%0d byte=%h line=%0d col=%0d err=%0d last=%0b",
                             $realtime, got.ev, got.kind, got.text, got.line, got.column,
                             got.err, got.last);
            end else begin
                want = tokens_due.pop_front();
                if (got !== want) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: mismatch exp ev=%0d kind=%0d byte=%h line=%0d col=%0d err=%0d last=%0b | got ev=%0d kind=%0d byte=%h line=%0d col=%0d err=%0d last=%0b",
                                 $realtime, want.ev, want.kind, want.text, want.line,
                                 want.column, want.err, want.last, got.ev, got.kind,
                                 got.text, got.line, got.column, got.err, got.last);
                end
            end
        end
    end

endmodule
